[src/rank_regression_loss_stream_unit_defines.svh]
// Assertion macros for the rank regression loss block.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef RANK_REGRESSION_LOSS_STREAM_UNIT_DEFINES_SVH
`define RANK_REGRESSION_LOSS_STREAM_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RRLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RRLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rrls_pkg.sv]
`timescale 1ns / 1ps

package rrls_pkg;

	// float unit operations
	localparam logic [2:0] FOP_ADD = 3'd0;
	localparam logic [2:0] FOP_SUB = 3'd1;
	localparam logic [2:0] FOP_MUL = 3'd2;
	localparam logic [2:0] FOP_DIV = 3'd3;
	localparam logic [2:0] FOP_I2F = 3'd4;

	localparam logic [63:0] DBL_ZERO   = 64'h0000_0000_0000_0000;
	localparam logic [63:0] DBL_ONE    = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DBL_HALF   = 64'h3FE0_0000_0000_0000;
	localparam logic [63:0] DBL_TWELVE = 64'h4028_0000_0000_0000;
	localparam logic [63:0] DBL_QNAN   = 64'hFFF8_0000_0000_0000;

	typedef struct packed {
		logic       start;
		logic [2:0] op;
		logic       neg;   // sign for integer conversion
	} fpu_req_t;

endpackage

[src/rrls_key_if.sv]
`timescale 1ns / 1ps

interface rrls_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key;
	logic        last;

	modport source (output valid, output key, output last, input ready);
	modport sink (input valid, input key, input last, output ready);
endinterface

[src/rrls_loss_if.sv]
`timescale 1ns / 1ps

interface rrls_loss_if;
	logic        valid;
	logic        ready;
	logic [63:0] loss;
	logic        zero_variance;

	modport source (output valid, output loss, output zero_variance, input ready);
	modport sink (input valid, input loss, input zero_variance, output ready);
endinterface

[src/rrls_fpu.sv]
`timescale 1ns / 1ps

// Multi-cycle IEEE double unit: add, subtract, multiply, divide, int to double.
// Round to nearest even.
module rrls_fpu (
	input  logic             clk,
	input  logic             arst_n,
	input  rrls_pkg::fpu_req_t req,
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	output logic             done,
	output logic [63:0]      res
);
	import rrls_pkg::*;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_PRE  = 3'd1;
	localparam logic [2:0] F_MUL  = 3'd2;
	localparam logic [2:0] F_DIV  = 3'd3;
	localparam logic [2:0] F_ADD  = 3'd4;
	localparam logic [2:0] F_NORM = 3'd5;
	localparam logic [2:0] F_DEN  = 3'd6;
	localparam logic [2:0] F_RND  = 3'd7;

	logic [2:0]         state_q;
	logic [2:0]         op_q;
	logic               s_q;
	logic               sub_q;
	logic signed [13:0] e_q;
	logic signed [13:0] ea_q;
	logic signed [13:0] eb_q;
	logic [52:0]        ma_q;
	logic [52:0]        mb_q;
	logic [63:0]        m_q;
	logic [63:0]        al_q;
	logic               stk_q;
	logic [105:0]       acc_q;
	logic [53:0]        rem_q;
	logic [6:0]         cnt_q;
	logic [63:0]        res_q;
	logic               done_q;

	// operand decode
	logic [10:0] a_ex, b_ex;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic        sb, sx;
	logic [63:0] a_quiet, b_quiet;

	always_comb begin
		a_ex    = a[62:52];
		b_ex    = b[62:52];
		a_nan   = (a_ex == 11'h7FF) && (a[51:0] != 52'd0);
		b_nan   = (b_ex == 11'h7FF) && (b[51:0] != 52'd0);
		a_inf   = (a_ex == 11'h7FF) && (a[51:0] == 52'd0);
		b_inf   = (b_ex == 11'h7FF) && (b[51:0] == 52'd0);
		a_zero  = (a[62:0] == 63'd0);
		b_zero  = (b[62:0] == 63'd0);
		sb      = b[63] ^ (req.op == FOP_SUB);
		sx      = a[63] ^ b[63];
		a_quiet = {a[63:52], 1'b1, a[50:0]};
		b_quiet = {b[63:52], 1'b1, b[50:0]};
	end

	// special operands resolve at once
	logic        spec;
	logic [63:0] spec_val;

	always_comb begin
		spec     = 1'b1;
		spec_val = DBL_ZERO;
		case (req.op)
			FOP_ADD, FOP_SUB: begin
				if (a_nan) spec_val = a_quiet;
				else if (b_nan) spec_val = b_quiet;
				else if (a_inf && b_inf && (a[63] != sb)) spec_val = DBL_QNAN;
				else if (a_inf) spec_val = a;
				else if (b_inf) spec_val = {sb, b[62:0]};
				else if (a_zero && b_zero) spec_val = {a[63] & sb, 63'd0};
				else if (a_zero) spec_val = {sb, b[62:0]};
				else if (b_zero) spec_val = a;
				else spec = 1'b0;
			end
			FOP_MUL: begin
				if (a_nan) spec_val = a_quiet;
				else if (b_nan) spec_val = b_quiet;
				else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = DBL_QNAN;
				else if (a_inf || b_inf) spec_val = {sx, 11'h7FF, 52'd0};
				else if (a_zero || b_zero) spec_val = {sx, 63'd0};
				else spec = 1'b0;
			end
			FOP_DIV: begin
				if (a_nan) spec_val = a_quiet;
				else if (b_nan) spec_val = b_quiet;
				else if ((a_inf && b_inf) || (a_zero && b_zero)) spec_val = DBL_QNAN;
				else if (a_inf || b_zero) spec_val = {sx, 11'h7FF, 52'd0};
				else if (b_inf || a_zero) spec_val = {sx, 63'd0};
				else spec = 1'b0;
			end
			FOP_I2F: begin
				spec = (a == 64'd0);
			end
			default: begin
				spec = 1'b1;
			end
		endcase
	end

	// addend alignment
	logic        a_big;
	logic [10:0] big_ex, sml_ex, bge, sge, diff;
	logic [51:0] big_fr, sml_fr;
	logic [63:0] big_m, sml_m, sml_sh, al;
	logic        sml_lost;

	always_comb begin
		a_big    = (a[62:0] >= b[62:0]);
		big_ex   = a_big ? a_ex : b_ex;
		sml_ex   = a_big ? b_ex : a_ex;
		big_fr   = a_big ? a[51:0] : b[51:0];
		sml_fr   = a_big ? b[51:0] : a[51:0];
		bge      = (big_ex == 11'd0) ? 11'd1 : big_ex;
		sge      = (sml_ex == 11'd0) ? 11'd1 : sml_ex;
		diff     = bge - sge;
		big_m    = {1'b0, big_ex != 11'd0, big_fr, 10'd0};
		sml_m    = {1'b0, sml_ex != 11'd0, sml_fr, 10'd0};
		sml_sh   = sml_m >> diff[5:0];
		sml_lost = |(sml_m & ~({64{1'b1}} << diff[5:0]));
		al       = (diff >= 11'd64) ? 64'd1 : (sml_sh | {63'd0, sml_lost});
	end

	// one 32x32 partial product per cycle
	logic [31:0]  px, py;
	logic [63:0]  pp;
	logic [105:0] pp_sh;

	always_comb begin
		px = cnt_q[1] ? {11'd0, ma_q[52:32]} : ma_q[31:0];
		py = cnt_q[0] ? {11'd0, mb_q[52:32]} : mb_q[31:0];
		pp = px * py;
		case (cnt_q[1:0])
			2'd0:    pp_sh = {42'd0, pp};
			2'd3:    pp_sh = {pp[41:0], 64'd0};
			default: pp_sh = {10'd0, pp, 32'd0};
		endcase
	end

	// restoring division step
	logic        rem_ge;
	logic [53:0] rem_nx;

	always_comb begin
		rem_ge = (rem_q >= {1'b0, mb_q});
		rem_nx = rem_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
	end

	// rounding
	logic [62:0] fld;
	logic        rnd_up;

	always_comb begin
		fld    = m_q[63] ? {e_q[10:0], m_q[62:11]} : {11'd0, m_q[62:11]};
		rnd_up = m_q[10] & ((|m_q[9:0]) | stk_q | m_q[11]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						stk_q <= 1'b0;
						if (spec) begin
							res_q  <= spec_val;
							done_q <= 1'b1;
						end else begin
							case (req.op)
								FOP_ADD, FOP_SUB: begin
									s_q     <= a_big ? a[63] : sb;
									sub_q   <= a[63] ^ sb;
									m_q     <= big_m;
									al_q    <= al;
									e_q     <= $signed({3'b000, bge}) + 14'sd1;
									state_q <= F_ADD;
								end
								FOP_MUL, FOP_DIV: begin
									s_q     <= sx;
									ma_q    <= {a_ex != 11'd0, a[51:0]};
									mb_q    <= {b_ex != 11'd0, b[51:0]};
									ea_q    <= $signed({3'b000, (a_ex == 11'd0) ? 11'd1 : a_ex});
									eb_q    <= $signed({3'b000, (b_ex == 11'd0) ? 11'd1 : b_ex});
									state_q <= F_PRE;
								end
								default: begin
									s_q     <= req.neg;
									m_q     <= a;
									e_q     <= 14'sd1086;
									state_q <= F_NORM;
								end
							endcase
						end
					end
				end
				F_PRE: begin
					cnt_q <= 7'd0;
					if (!ma_q[52]) begin
						if (ma_q[52:37] == 16'd0) begin
							ma_q <= {ma_q[36:0], 16'd0};
							ea_q <= ea_q - 14'sd16;
						end else begin
							ma_q <= {ma_q[51:0], 1'b0};
							ea_q <= ea_q - 14'sd1;
						end
					end else if (!mb_q[52]) begin
						if (mb_q[52:37] == 16'd0) begin
							mb_q <= {mb_q[36:0], 16'd0};
							eb_q <= eb_q - 14'sd16;
						end else begin
							mb_q <= {mb_q[51:0], 1'b0};
							eb_q <= eb_q - 14'sd1;
						end
					end else if (op_q == FOP_MUL) begin
						acc_q   <= 106'd0;
						state_q <= F_MUL;
					end else begin
						rem_q   <= {1'b0, ma_q};
						state_q <= F_DIV;
					end
				end
				F_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd4) begin
						m_q     <= acc_q[105:42];
						stk_q   <= |acc_q[41:0];
						e_q     <= ea_q + eb_q - 14'sd1022;
						state_q <= F_NORM;
					end else begin
						acc_q <= acc_q + pp_sh;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) begin
						stk_q   <= (rem_q != 54'd0);
						e_q     <= ea_q - eb_q + 14'sd1023;
						state_q <= F_NORM;
					end else begin
						m_q   <= {m_q[62:0], rem_ge};
						rem_q <= {rem_nx[52:0], 1'b0};
					end
				end
				F_ADD: begin
					if (sub_q) begin
						m_q <= m_q - al_q;
						if (m_q == al_q) s_q <= 1'b0;   // exact cancellation gives +0
					end else begin
						m_q <= m_q + al_q;
					end
					state_q <= F_NORM;
				end
				F_NORM: begin
					if (m_q == 64'd0) begin
						res_q   <= {s_q, 63'd0};
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else if (!m_q[63]) begin
						if (m_q[63:48] == 16'd0) begin
							m_q <= {m_q[47:0], 16'd0};
							e_q <= e_q - 14'sd16;
						end else if (m_q[63:60] == 4'd0) begin
							m_q <= {m_q[59:0], 4'd0};
							e_q <= e_q - 14'sd4;
						end else begin
							m_q <= {m_q[62:0], 1'b0};
							e_q <= e_q - 14'sd1;
						end
					end else if (e_q >= 14'sd2047) begin
						res_q   <= {s_q, 11'h7FF, 52'd0};
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else if (e_q < 14'sd1) begin
						state_q <= F_DEN;
					end else begin
						state_q <= F_RND;
					end
				end
				F_DEN: begin
					// subnormal: shift right until the exponent reaches one
					if (e_q >= 14'sd1) begin
						state_q <= F_RND;
					end else if (e_q < -14'sd62) begin
						stk_q <= stk_q | (m_q != 64'd0);
						m_q   <= 64'd0;
						e_q   <= 14'sd1;
					end else if (e_q < -14'sd14) begin
						stk_q <= stk_q | (m_q[15:0] != 16'd0);
						m_q   <= {16'd0, m_q[63:16]};
						e_q   <= e_q + 14'sd16;
					end else begin
						stk_q <= stk_q | m_q[0];
						m_q   <= {1'b0, m_q[63:1]};
						e_q   <= e_q + 14'sd1;
					end
				end
				F_RND: begin
					res_q   <= {s_q, fld + {62'd0, rnd_up}};
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[src/rank_regression_loss_stream_unit.sv]
`timescale 1ns / 1ps

// Rank regression loss over a stream of keys. Each key transaction gets the
// next rank (1, 2, ...) within the current set; the block accumulates IEEE
// double sums of x, x*rank and x*x, where x is the key as a double (key_format
// = 1) or the unsigned key minus the set's first key (key_format = 0). The
// transaction with last set closes the set and yields one result transaction:
// the residual variance var_y - cov^2/var_x of a least-squares line of rank on
// x, or zero_variance = 1 with loss = 0 when var_x is exactly zero. Sums and
// count then clear. All arithmetic goes through one shared double unit with
// round to nearest even, driven by a step sequencer, so the block takes one
// key at a time: a key runs seven dependent unit operations (six with double
// keys), where a multiply sums four partial products, and the last key of a
// set then runs the closing steps, among them up to five divisions. A
// finished result sits in an output register, so the next key is taken
// while the result waits. key_format is to be written through cfg_we /
// cfg_wdata only while the block is idle; the block itself does not
// enforce this.
module rank_regression_loss_stream_unit #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	rrls_key_if.sink    item,
	rrls_loss_if.source result
);
	import rrls_pkg::*;

	// sequencer steps
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_X    = 5'd1;   // key to double
	localparam logic [4:0] S_Y    = 5'd2;   // rank to double
	localparam logic [4:0] S_P1   = 5'd3;   // x * rank
	localparam logic [4:0] S_A1   = 5'd4;
	localparam logic [4:0] S_P2   = 5'd5;   // x * x
	localparam logic [4:0] S_A2   = 5'd6;
	localparam logic [4:0] S_A3   = 5'd7;   // sum of x
	localparam logic [4:0] S_L1   = 5'd8;   // n + 1
	localparam logic [4:0] S_L2   = 5'd9;   // mean_y
	localparam logic [4:0] S_L3   = 5'd10;  // n * n
	localparam logic [4:0] S_L4   = 5'd11;
	localparam logic [4:0] S_L5   = 5'd12;  // var_y
	localparam logic [4:0] S_L6   = 5'd13;  // mean_x
	localparam logic [4:0] S_L7   = 5'd14;
	localparam logic [4:0] S_L8   = 5'd15;
	localparam logic [4:0] S_L9   = 5'd16;  // cov
	localparam logic [4:0] S_L10  = 5'd17;
	localparam logic [4:0] S_L11  = 5'd18;
	localparam logic [4:0] S_L12  = 5'd19;  // var_x, zero test
	localparam logic [4:0] S_L13  = 5'd20;  // cov^2
	localparam logic [4:0] S_L14  = 5'd21;
	localparam logic [4:0] S_L15  = 5'd22;  // loss
	localparam logic [4:0] S_OUT  = 5'd23;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [4:0]            state_q;
	logic                  busy_q;
	logic                  fmt_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [63:0]           first_q;
	logic [63:0]           key_q;
	logic                  last_q;

	// double registers
	logic [63:0] skeys_q, srank_q, ssq_q;
	logic [63:0] x_q, y_q, t_q, u_q, my_q, vy_q, mx_q, cov_q;

	// result register; zp_q holds the zero test until the slot frees up
	logic        ov_q;
	logic [63:0] loss_q;
	logic        zv_q;
	logic        zp_q;

	logic        accept;
	logic        key_ge;
	fpu_req_t    req;
	logic [63:0] opa, opb;
	logic        fpu_done;
	logic [63:0] fpu_res;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign key_ge     = (key_q >= first_q);

	// operand selection per step
	always_comb begin
		req.start = !busy_q && (state_q inside {[S_X:S_L15]}) && !((state_q == S_X) && fmt_q);
		req.op    = FOP_ADD;
		req.neg   = 1'b0;
		opa       = DBL_ZERO;
		opb       = DBL_ZERO;
		case (state_q)
			S_X: begin
				req.op  = FOP_I2F;
				req.neg = !key_ge;
				opa     = key_ge ? (key_q - first_q) : (first_q - key_q);
			end
			S_Y: begin
				req.op = FOP_I2F;
				opa    = {{(64-COUNT_BITS){1'b0}}, count_q};
			end
			S_P1:  begin req.op = FOP_MUL; opa = x_q;     opb = y_q;        end
			S_A1:  begin req.op = FOP_ADD; opa = srank_q; opb = t_q;        end
			S_P2:  begin req.op = FOP_MUL; opa = x_q;     opb = x_q;        end
			S_A2:  begin req.op = FOP_ADD; opa = ssq_q;   opb = t_q;        end
			S_A3:  begin req.op = FOP_ADD; opa = skeys_q; opb = x_q;        end
			S_L1:  begin req.op = FOP_ADD; opa = y_q;     opb = DBL_ONE;    end
			S_L2:  begin req.op = FOP_MUL; opa = t_q;     opb = DBL_HALF;   end
			S_L3:  begin req.op = FOP_MUL; opa = y_q;     opb = y_q;        end
			S_L4:  begin req.op = FOP_SUB; opa = t_q;     opb = DBL_ONE;    end
			S_L5:  begin req.op = FOP_DIV; opa = t_q;     opb = DBL_TWELVE; end
			S_L6:  begin req.op = FOP_DIV; opa = skeys_q; opb = y_q;        end
			S_L7:  begin req.op = FOP_DIV; opa = srank_q; opb = y_q;        end
			S_L8:  begin req.op = FOP_MUL; opa = mx_q;    opb = my_q;       end
			S_L9:  begin req.op = FOP_SUB; opa = t_q;     opb = u_q;        end
			S_L10: begin req.op = FOP_DIV; opa = ssq_q;   opb = y_q;        end
			S_L11: begin req.op = FOP_MUL; opa = mx_q;    opb = mx_q;       end
			S_L12: begin req.op = FOP_SUB; opa = t_q;     opb = u_q;        end
			S_L13: begin req.op = FOP_MUL; opa = cov_q;   opb = cov_q;      end
			S_L14: begin req.op = FOP_DIV; opa = t_q;     opb = u_q;        end
			S_L15: begin req.op = FOP_SUB; opa = vy_q;    opb = t_q;        end
			default: begin
				req.op = FOP_ADD;
			end
		endcase
	end

	rrls_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (opa),
		.b      (opb),
		.done   (fpu_done),
		.res    (fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			fmt_q   <= 1'b0;
			count_q <= '0;
			first_q <= 64'd0;
			skeys_q <= DBL_ZERO;
			srank_q <= DBL_ZERO;
			ssq_q   <= DBL_ZERO;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) fmt_q <= cfg_wdata;
			if (req.start) busy_q <= 1'b1;
			if (fpu_done) busy_q <= 1'b0;
			if (result.valid && result.ready) ov_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q  <= item.key;
						last_q <= item.last;
						if (count_q == '0) first_q <= item.key;
						if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
						state_q <= S_X;
					end
				end
				S_OUT: begin
					// one result slot: wait until the previous one is taken
					if (!ov_q || result.ready) begin
						ov_q    <= 1'b1;
						loss_q  <= zp_q ? DBL_ZERO : t_q;
						zv_q    <= zp_q;
						count_q <= '0;
						first_q <= 64'd0;
						skeys_q <= DBL_ZERO;
						srank_q <= DBL_ZERO;
						ssq_q   <= DBL_ZERO;
						state_q <= S_IDLE;
					end
				end
				default: begin
					if ((state_q == S_X) && fmt_q) begin
						x_q     <= key_q;   // key bits are the double itself
						state_q <= S_Y;
					end else if (fpu_done) begin
						state_q <= state_q + 5'd1;
						case (state_q)
							S_X:   x_q     <= fpu_res;
							S_Y:   y_q     <= fpu_res;
							S_P1:  t_q     <= fpu_res;
							S_A1:  srank_q <= fpu_res;
							S_P2:  t_q     <= fpu_res;
							S_A2:  ssq_q   <= fpu_res;
							S_A3: begin
								skeys_q <= fpu_res;
								if (!last_q) state_q <= S_IDLE;
							end
							S_L1:  t_q     <= fpu_res;
							S_L2:  my_q    <= fpu_res;
							S_L3:  t_q     <= fpu_res;
							S_L4:  t_q     <= fpu_res;
							S_L5:  vy_q    <= fpu_res;
							S_L6:  mx_q    <= fpu_res;
							S_L7:  t_q     <= fpu_res;
							S_L8:  u_q     <= fpu_res;
							S_L9:  cov_q   <= fpu_res;
							S_L10: t_q     <= fpu_res;
							S_L11: u_q     <= fpu_res;
							S_L12: begin
								u_q  <= fpu_res;
								// either sign of zero counts as no key spread
								zp_q <= (fpu_res[62:0] == 63'd0);
								if (fpu_res[62:0] == 63'd0) state_q <= S_OUT;
							end
							S_L13: t_q     <= fpu_res;
							S_L14: t_q     <= fpu_res;
							S_L15: t_q     <= fpu_res;
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
			endcase
		end
	end

	assign result.valid         = ov_q;
	assign result.loss          = loss_q;
	assign result.zero_variance = zv_q;

endmodule

[src/rrls_checker.sv]
`timescale 1ns / 1ps
`include "rank_regression_loss_stream_unit_defines.svh"

module rrls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [63:0] result_loss,
	input logic        result_zero_variance
);

	`RRLS_ASSERT_NEXT(a_busy_after_item, item_valid && item_ready, !item_ready, "ready stayed high after a key")
	`RRLS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")
	`RRLS_ASSERT_NOW(a_result_after_work, $rose(result_valid), $past(!item_ready), "result without finished work")
	`RRLS_ASSERT_NOW(a_zero_var_loss, result_valid && result_zero_variance, result_loss == 64'd0, "zero variance with nonzero loss")

endmodule

bind rank_regression_loss_stream_unit rrls_checker u_rrls_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.item_valid           (item.valid),
	.item_ready           (item.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.result_loss          (result.loss),
	.result_zero_variance (result.zero_variance)
);
